FILE: design/cma_pkg.sv
// Shared types and constants for the centered moving average core.
// No dependencies; used by cma_ring, cma_div and centered_moving_average_core.
`default_nettype none

package cma_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W = 16;   // input sample
	localparam int MEAN_W   = 20;   // mean, 4 fraction bits
	localparam int SUM_W    = 21;   // signed window sum over up to 31 samples
	localparam int IDX_W    = 5;    // ring index, sample counts
	localparam int HW_W     = 4;    // half_width register
	localparam int FRAC_W   = 4;    // fraction bits of the mean
	localparam int X_W      = 24;   // |sum| scaled by 16
	localparam int RECIP_W  = 25;   // reciprocal, 2^24 / d
	localparam int PROD_W   = X_W + RECIP_W;
	localparam int QD_W     = X_W + IDX_W;

	localparam int RING_DEPTH = 32;
	localparam logic [IDX_W-1:0] SEEN_CAP = 5'd31;
	localparam logic [HW_W-1:0]  HW_RESET = 4'd2;

	// Reciprocal table, floor(2^24 / d); entry 0 never used
	localparam int RECIP_NUM = 16777216;
	localparam logic [RECIP_W-1:0] RECIP [32] = '{
		25'd0,
		25'(RECIP_NUM / 1),  25'(RECIP_NUM / 2),  25'(RECIP_NUM / 3),  25'(RECIP_NUM / 4),
		25'(RECIP_NUM / 5),  25'(RECIP_NUM / 6),  25'(RECIP_NUM / 7),  25'(RECIP_NUM / 8),
		25'(RECIP_NUM / 9),  25'(RECIP_NUM / 10), 25'(RECIP_NUM / 11), 25'(RECIP_NUM / 12),
		25'(RECIP_NUM / 13), 25'(RECIP_NUM / 14), 25'(RECIP_NUM / 15), 25'(RECIP_NUM / 16),
		25'(RECIP_NUM / 17), 25'(RECIP_NUM / 18), 25'(RECIP_NUM / 19), 25'(RECIP_NUM / 20),
		25'(RECIP_NUM / 21), 25'(RECIP_NUM / 22), 25'(RECIP_NUM / 23), 25'(RECIP_NUM / 24),
		25'(RECIP_NUM / 25), 25'(RECIP_NUM / 26), 25'(RECIP_NUM / 27), 25'(RECIP_NUM / 28),
		25'(RECIP_NUM / 29), 25'(RECIP_NUM / 30), 25'(RECIP_NUM / 31)
	};

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE_SUB,
		ST_WRITE,
		ST_PLAN,
		ST_TGT,
		ST_ADJ,
		ST_ADJ_UPD,
		ST_DIV,
		ST_DIV_WAIT,
		ST_EMIT
	} cma_state_t;

	// Ring write port
	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    addr;
		logic [SAMPLE_W-1:0] data;
	} cma_ring_wr_t;

	// Divider request
	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] sum;
		logic [IDX_W-1:0]        size;
	} cma_div_req_t;

endpackage

`default_nettype wire

FILE: design/cma_ring.sv
// Sample ring: 32 x 16 synchronous memory, one write and one read port,
// read data registered. Depends on cma_pkg.
`default_nettype none

module cma_ring (
	input  wire logic                           clk,
	input  wire cma_pkg::cma_ring_wr_t          wr,
	input  wire logic [cma_pkg::IDX_W-1:0]      raddr,
	output logic      [cma_pkg::SAMPLE_W-1:0]   rdata
);

	logic [cma_pkg::SAMPLE_W-1:0] mem [cma_pkg::RING_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/cma_div.sv
// Four-stage divider: (sum * 16) / size, truncated toward zero, by a
// reciprocal multiply and one correction step. Depends on cma_pkg.
`default_nettype none

module cma_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cma_pkg::cma_div_req_t              req,
	output logic                                    done,
	output logic      [cma_pkg::MEAN_W-1:0]         mean
);

	logic                               v_s1, v_s2, v_s3;
	logic                               done_q;
	logic                               neg_s1, neg_s2, neg_s3;
	logic [cma_pkg::X_W-1:0]            x_s1, x_s2, x_s3;
	logic [cma_pkg::IDX_W-1:0]          d_s1, d_s2, d_s3;
	logic [cma_pkg::RECIP_W-1:0]        r_s1;
	logic [cma_pkg::PROD_W-1:0]         prod_s2;
	logic [cma_pkg::X_W-1:0]            q0_s3;
	logic [cma_pkg::QD_W-1:0]           qd_s3;
	logic [cma_pkg::MEAN_W-1:0]         mean_q;

	logic [cma_pkg::SUM_W-1:0]          abs_sum;
	logic [cma_pkg::X_W-1:0]            q0_c;
	logic [cma_pkg::QD_W-1:0]           rem_c;
	logic [cma_pkg::X_W-1:0]            q_c;

	// magnitude of the sum
	assign abs_sum = req.sum[cma_pkg::SUM_W-1] ? (-req.sum) : req.sum;

	// quotient estimate from the product
	assign q0_c = prod_s2[2*cma_pkg::X_W-1:cma_pkg::X_W];

	// correction: estimate is exact or one low
	assign rem_c = {{cma_pkg::IDX_W{1'b0}}, x_s3} - qd_s3;
	assign q_c   = (rem_c >= cma_pkg::QD_W'(d_s3)) ? (q0_s3 + 1'b1) : q0_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= req.start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_s1 <= req.sum[cma_pkg::SUM_W-1];
			x_s1   <= {abs_sum[cma_pkg::X_W-cma_pkg::FRAC_W-1:0],
				{cma_pkg::FRAC_W{1'b0}}};
			d_s1   <= req.size;
			r_s1   <= cma_pkg::RECIP[req.size];
		end
		if (v_s1) begin
			prod_s2 <= cma_pkg::PROD_W'(x_s1) * cma_pkg::PROD_W'(r_s1);
			x_s2    <= x_s1;
			d_s2    <= d_s1;
			neg_s2  <= neg_s1;
		end
		if (v_s2) begin
			q0_s3  <= q0_c;
			qd_s3  <= cma_pkg::QD_W'(q0_c) * cma_pkg::QD_W'(d_s2);
			x_s3   <= x_s2;
			d_s3   <= d_s2;
			neg_s3 <= neg_s2;
		end
		if (v_s3) begin
			mean_q <= neg_s3 ? (-q_c[cma_pkg::MEAN_W-1:0]) : q_c[cma_pkg::MEAN_W-1:0];
		end
	end

	assign done = done_q;
	assign mean = mean_q;

endmodule

`default_nettype wire

FILE: design/centered_moving_average_core.sv
// Centered moving average with windows clipped at the waveform ends.
// Depends on cma_pkg, cma_ring (sample memory) and cma_div (divider).
//
//   channel   signals                             direction  handshake
//   samples   sample, last                        in         sample_valid / sample_stall
//   means     mean_q4, last_out                   out        mean_valid / mean_stall
//   config    cfg_data (half_width)               in         cfg_valid / cfg_ready
//
// One sample at a time: a new sample is taken only in idle. The pace is set by
// the single read port of the ring (one read per sample added to or removed
// from the running sum) and the four-stage divider. A flush on last repeats
// the window adjustment and the division for each further pending mean.
// Reset clears the counters, the sum and half_width (to 2); the ring is not cleared.
// A held output beat does not block the next sample; the sequencer waits on the
// output only when it has a new mean and the output register is still full.
`default_nettype none

module centered_moving_average_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// samples
	input  wire logic                                  sample_valid,
	output logic                                       sample_stall,
	input  wire logic signed [cma_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                                  last,
	// means
	output logic                                       mean_valid,
	input  wire logic                                  mean_stall,
	output logic signed      [cma_pkg::MEAN_W-1:0]     mean_q4,
	output logic                                       last_out,
	// configuration
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic        [cma_pkg::HW_W-1:0]       cfg_data
);

	cma_pkg::cma_state_t                 state_q, state_d;
	logic [cma_pkg::HW_W-1:0]            hw_q;
	logic [cma_pkg::IDX_W-1:0]           wr_q;
	logic [cma_pkg::IDX_W-1:0]           cnt_q;
	logic [cma_pkg::IDX_W-1:0]           seen_q;
	logic signed [cma_pkg::SUM_W-1:0]    sum_q;
	logic [cma_pkg::SAMPLE_W-1:0]        samp_q;
	logic                                last_q;
	logic [cma_pkg::HW_W-1:0]            k_q;
	logic [cma_pkg::IDX_W-1:0]           tgt_q;
	logic                                dir_q;
	logic                                out_valid_q;
	logic [cma_pkg::MEAN_W-1:0]          out_mean_q;
	logic                                out_last_q;

	cma_pkg::cma_ring_wr_t               ring_wr;
	logic [cma_pkg::IDX_W-1:0]           ring_raddr;
	logic [cma_pkg::SAMPLE_W-1:0]        ring_rdata;
	cma_pkg::cma_div_req_t               div_req;
	logic                                div_done;
	logic [cma_pkg::MEAN_W-1:0]          div_mean;

	logic                                in_acc;
	logic                                out_free;
	logic                                out_load;
	logic [cma_pkg::IDX_W-1:0]           hw_ext;
	logic [cma_pkg::IDX_W-1:0]           full_c;
	logic [cma_pkg::IDX_W-1:0]           seen_inc;
	logic                                reach_c;
	logic [cma_pkg::IDX_W-1:0]           kmax_c;
	logic [cma_pkg::IDX_W-1:0]           flush_sz;
	logic [cma_pkg::IDX_W-1:0]           tgt_c;
	logic signed [cma_pkg::SUM_W-1:0]    in_ext, samp_ext, rd_ext;

	// ---- handshake and small helpers ----
	assign in_acc   = sample_valid && (state_q == cma_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !mean_stall;
	assign out_load = (state_q == cma_pkg::ST_EMIT) && out_free;

	assign hw_ext   = {1'b0, hw_q};
	assign full_c   = {hw_q, 1'b1};
	assign seen_inc = (seen_q == cma_pkg::SEEN_CAP) ? seen_q : (seen_q + 1'b1);
	assign reach_c  = seen_q >= (hw_ext + 1'b1);
	assign kmax_c   = ((seen_q - 1'b1) > hw_ext) ? hw_ext : (seen_q - 1'b1);
	assign flush_sz = {1'b0, k_q} + hw_ext + 1'b1;

	// window size for the next mean
	always_comb begin
		if (last_q) begin
			tgt_c = (flush_sz > seen_q) ? seen_q : flush_sz;
		end else begin
			tgt_c = (seen_q < full_c) ? seen_q : full_c;
		end
	end

	assign in_ext   = {{(cma_pkg::SUM_W-cma_pkg::SAMPLE_W){sample[cma_pkg::SAMPLE_W-1]}}, sample};
	assign samp_ext = {{(cma_pkg::SUM_W-cma_pkg::SAMPLE_W){samp_q[cma_pkg::SAMPLE_W-1]}}, samp_q};
	assign rd_ext   = {{(cma_pkg::SUM_W-cma_pkg::SAMPLE_W){ring_rdata[cma_pkg::SAMPLE_W-1]}},
		ring_rdata};

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cma_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = (cnt_q == cma_pkg::SEEN_CAP) ? cma_pkg::ST_PRE_SUB
						: cma_pkg::ST_PLAN;
				end
			end
			cma_pkg::ST_PRE_SUB:  state_d = cma_pkg::ST_WRITE;
			cma_pkg::ST_WRITE:    state_d = cma_pkg::ST_PLAN;
			cma_pkg::ST_PLAN: begin
				state_d = (last_q || reach_c) ? cma_pkg::ST_TGT : cma_pkg::ST_IDLE;
			end
			cma_pkg::ST_TGT:      state_d = cma_pkg::ST_ADJ;
			cma_pkg::ST_ADJ: begin
				state_d = (cnt_q == tgt_q) ? cma_pkg::ST_DIV : cma_pkg::ST_ADJ_UPD;
			end
			cma_pkg::ST_ADJ_UPD:  state_d = cma_pkg::ST_ADJ;
			cma_pkg::ST_DIV:      state_d = cma_pkg::ST_DIV_WAIT;
			cma_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = cma_pkg::ST_EMIT;
				end
			end
			cma_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = (last_q && (k_q != '0)) ? cma_pkg::ST_TGT : cma_pkg::ST_IDLE;
				end
			end
			default:              state_d = cma_pkg::ST_IDLE;
		endcase
	end

	// ---- memory and divider controls ----
	always_comb begin
		ring_wr.en    = 1'b0;
		ring_wr.addr  = wr_q;
		ring_wr.data  = samp_q;
		ring_raddr    = wr_q - cnt_q;
		div_req.start = 1'b0;
		div_req.sum   = sum_q;
		div_req.size  = cnt_q;
		unique case (state_q)
			cma_pkg::ST_IDLE: begin
				// oldest entry read ahead in case the window is at capacity
				ring_wr.en   = in_acc && (cnt_q != cma_pkg::SEEN_CAP);
				ring_wr.data = sample;
			end
			cma_pkg::ST_WRITE: begin
				ring_wr.en = 1'b1;
			end
			cma_pkg::ST_ADJ: begin
				// shrink drops the oldest entry, grow adds the next older one
				ring_raddr = (cnt_q > tgt_q) ? (wr_q - cnt_q) : (wr_q - cnt_q - 1'b1);
			end
			cma_pkg::ST_DIV: begin
				div_req.start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// ---- sequencer registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cma_pkg::ST_IDLE;
			wr_q        <= '0;
			cnt_q       <= '0;
			seen_q      <= '0;
			sum_q       <= '0;
			last_q      <= 1'b0;
			k_q         <= '0;
			tgt_q       <= '0;
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!mean_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				cma_pkg::ST_IDLE: begin
					if (in_acc) begin
						last_q <= last;
						if (cnt_q != cma_pkg::SEEN_CAP) begin
							wr_q   <= wr_q + 1'b1;
							cnt_q  <= cnt_q + 1'b1;
							sum_q  <= sum_q + in_ext;
							seen_q <= seen_inc;
						end
					end
				end
				cma_pkg::ST_PRE_SUB: begin
					sum_q <= sum_q - rd_ext;
					cnt_q <= cnt_q - 1'b1;
				end
				cma_pkg::ST_WRITE: begin
					wr_q   <= wr_q + 1'b1;
					cnt_q  <= cnt_q + 1'b1;
					sum_q  <= sum_q + samp_ext;
					seen_q <= seen_inc;
				end
				cma_pkg::ST_PLAN: begin
					k_q <= kmax_c[cma_pkg::HW_W-1:0];
				end
				cma_pkg::ST_TGT: begin
					tgt_q <= tgt_c;
				end
				cma_pkg::ST_ADJ: begin
					dir_q <= cnt_q < tgt_q;
				end
				cma_pkg::ST_ADJ_UPD: begin
					if (dir_q) begin
						sum_q <= sum_q + rd_ext;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						sum_q <= sum_q - rd_ext;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				cma_pkg::ST_EMIT: begin
					// flush walks pending positions; waveform ends at k = 0
					if (out_free && last_q) begin
						if (k_q != '0) begin
							k_q <= k_q - 1'b1;
						end else begin
							seen_q <= '0;
							cnt_q  <= '0;
							sum_q  <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q <= sample;
		end
		if (out_load) begin
			out_mean_q <= div_mean;
			out_last_q <= last_q && (k_q == '0);
		end
	end

	// half_width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= cma_pkg::HW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hw_q <= cfg_data;
		end
	end

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != cma_pkg::ST_IDLE);
	assign mean_valid   = out_valid_q;
	assign mean_q4      = out_mean_q;
	assign last_out     = out_last_q;

	// ---- submodules ----
	cma_ring u_ring (
		.clk   (clk),
		.wr    (ring_wr),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	cma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.mean   (div_mean)
	);

	// ---- assertions ----
	// running sum never covers entries outside the current waveform
	a_cnt_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= seen_q)
		else $error("window count exceeds samples seen");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == cma_pkg::ST_DIV_WAIT))
		else $error("divider result outside wait state");

	// every window-adjust sum update follows a read issued in the previous cycle
	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cma_pkg::ST_ADJ_UPD) |-> ($past(state_q) == cma_pkg::ST_ADJ))
		else $error("sum update without ring read");

	// a loaded mean is presented on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> mean_valid)
		else $error("loaded mean not presented");

endmodule

`default_nettype wire

FILE: dv/centered_moving_average_core_test.sv
// Self-checking testbench for centered_moving_average_core: directed table, then random waveforms.
// Uses cma_pkg for the port widths; it carries its own model of the clipped-window mean.
`timescale 1ns / 1ps

module centered_moving_average_core_test;

	localparam int SW = cma_pkg::SAMPLE_W;
	localparam int MW = cma_pkg::MEAN_W;
	localparam int HW = cma_pkg::HW_W;

	localparam int RING_SIZE    = 32;
	localparam int SEEN_MAX     = 31;
	localparam int DRAIN_CYCLES = 64;    // sequencer can still be busy on a sample with no mean
	localparam int STALL_LIMIT  = 4000;  // cycles with no beat on any channel
	localparam int RANDOM_ITEMS = 80;
	localparam int DIR_ROWS     = 21;

	// One row of the directed table: a half_width write or a sample beat
	typedef struct packed {
		logic                 cfg_row;
		logic [HW-1:0]        hw;
		logic signed [SW-1:0] smp;
		logic                 lst_in;
		logic                 typed;    // expected mean given in the row
		logic signed [MW-1:0] mean_x;
		logic                 last_x;
	} stim_row_t;

	typedef struct {
		logic signed [MW-1:0] mean;
		logic                 lst;
	} mean_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [SW-1:0] sample = '0;
	logic last = 1'b0;
	logic mean_valid;
	logic mean_stall = 1'b0;
	logic signed [MW-1:0] mean_q4;
	logic last_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [HW-1:0] cfg_data = '0;

	// Model state
	logic signed [SW-1:0] ring_m [RING_SIZE];
	logic [4:0]           wr_m = '0;
	int                   seen_m = 0;
	int                   hw_m = 2;

	mean_beat_t mean_due_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit steady = 1'b0;    // no gaps on either side while set

	stim_row_t dir_tab [DIR_ROWS] = '{
		'{1'b0, 4'd0,  16'sh7FFF, 1'b1, 1'b1, 20'sd524272, 1'b1},  // full scale, last on first
		'{1'b0, 4'd0,  16'sh8000, 1'b1, 1'b1, 20'sh80000,  1'b1},  // negative full scale
		'{1'b1, 4'd0,  16'sd0,    1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sd5,    1'b0, 1'b1, 20'sd80,     1'b0},  // window of one
		'{1'b0, 4'd0,  -16'sd3,   1'b1, 1'b1, -20'sd48,    1'b1},
		'{1'b1, 4'd15, 16'sd0,    1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sd100,  1'b0, 1'b0, 20'sd0,      1'b0},  // short waveform
		'{1'b0, 4'd0,  -16'sd200, 1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sd301,  1'b1, 1'b0, 20'sd0,      1'b0},
		'{1'b1, 4'd2,  16'sd0,    1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sh8000, 1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sh8000, 1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sh8000, 1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sd7,    1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b1, 4'd1,  16'sd0,    1'b0, 1'b0, 20'sd0,      1'b0},  // change inside a waveform
		'{1'b0, 4'd0,  16'sd0,    1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  -16'sd1,   1'b1, 1'b0, 20'sd0,      1'b0},  // truncation toward zero
		'{1'b1, 4'd2,  16'sd0,    1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sh5555, 1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'shAAAA, 1'b0, 1'b0, 20'sd0,      1'b0},
		'{1'b0, 4'd0,  16'sd1,    1'b1, 1'b0, 20'sd0,      1'b0}
	};

	always #2 clk = ~clk;

	centered_moving_average_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.last         (last),
		.mean_valid   (mean_valid),
		.mean_stall   (mean_stall),
		.mean_q4      (mean_q4),
		.last_out     (last_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Gap length: mostly none, some short, a few long
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Truncated mean of the newest 'size' samples, 4 fraction bits
	function automatic logic signed [MW-1:0] window_mean(int size);
		longint acc;
		int j;
		acc = 0;
		for (j = 0; j < size; j++)
			acc += ring_m[(int'(wr_m) - 1 - j) & (RING_SIZE - 1)];
		acc = (acc * 16) / size;
		return acc[MW-1:0];
	endfunction

	// Append one expected mean beat at the tail of the queue
	function automatic void queue_mean(mean_beat_t nb);
		mean_due_q.insert(mean_due_q.size(), nb);
	endfunction

	// Advance the model by one sample and queue the means it releases
	function automatic void predict_means(logic signed [SW-1:0] s, logic l, bit queue_en);
		int h;
		int full;
		int size;
		int k;
		mean_beat_t b;
		ring_m[wr_m] = s;
		wr_m = wr_m + 5'd1;
		if (seen_m < SEEN_MAX)
			seen_m++;
		h = hw_m;
		full = 2 * h + 1;
		if (!l) begin
			if (seen_m >= h + 1) begin
				size = (seen_m < full) ? seen_m : full;
				b.mean = window_mean(size);
				b.lst = 1'b0;
				if (queue_en)
					queue_mean(b);
			end
		end else begin
			// flush every pending position, oldest first
			k = (seen_m - 1 > h) ? h : seen_m - 1;
			for (; k >= 0; k--) begin
				size = k + h + 1;
				if (size > seen_m)
					size = seen_m;
				b.mean = window_mean(size);
				b.lst = (k == 0);
				if (queue_en)
					queue_mean(b);
			end
			seen_m = 0;
		end
	endfunction

	// Drive one sample beat and wait until it is taken
	task automatic send_beat(logic signed [SW-1:0] s, logic l);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		last <= l;
		do @(posedge clk); while (sample_stall);
	endtask

	// Write half_width once the core has gone quiet
	task automatic write_half_width(logic [HW-1:0] v);
		sample_valid <= 1'b0;
		while (mean_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hw_m = v;
	endtask

	// Random sample value, weighted toward the rails and small values
	function automatic logic signed [SW-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'sh7FFF;
		if (r < 20)
			return 16'sh8000;
		if (r < 35)
			return SW'($urandom_range(0, 16) - 8);
		return SW'($urandom);
	endfunction

	// Output side: random stall stretches
	always @(posedge clk) begin
		if (stall_left > 0) begin
			mean_stall <= 1'b1;
			stall_left--;
		end else begin
			mean_stall <= 1'b0;
			stall_left = next_gap();
		end
	end

	// Result checker and activity counter
	always @(posedge clk) begin
		mean_beat_t want;
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (cfg_valid && cfg_ready) ||
				(mean_valid && !mean_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (mean_valid && !mean_stall) begin
				if (mean_due_q.size() == 0) begin
					$error("unexpected mean beat: mean_q4 %0d last_out %0b", mean_q4, last_out);
					errors++;
				end else begin
					want = mean_due_q.pop_front();
					if (mean_q4 !== want.mean) begin
						$error("mean_q4: expected %0d, got %0d", want.mean, mean_q4);
						errors++;
					end
					if (last_out !== want.lst) begin
						$error("last_out: expected %0b, got %0b", want.lst, last_out);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Stimulus
	initial begin
		int i;
		int sent;
		int waves;
		int len;
		int w;
		int r;
		mean_beat_t b;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].cfg_row) begin
				write_half_width(dir_tab[i].hw);
			end else begin
				send_beat(dir_tab[i].smp, dir_tab[i].lst_in);
				predict_means(dir_tab[i].smp, dir_tab[i].lst_in, !dir_tab[i].typed);
				if (dir_tab[i].typed) begin
					b.mean = dir_tab[i].mean_x;
					b.lst = dir_tab[i].last_x;
					queue_mean(b);
				end
			end
		end

		// random phases: each sets half_width, then a few waveforms;
		// every config write holds the sender until all means are back
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				write_half_width(4'd0);
			else if (r < 4)
				write_half_width(4'd15);
			else
				write_half_width(HW'($urandom_range(0, 15)));
			steady = ($urandom_range(0, 3) == 0);
			waves = $urandom_range(1, 3);
			for (w = 0; w < waves; w++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 10);
				for (i = 0; i < len; i++) begin
					// occasional change of half_width inside a waveform
					if (i > 0 && $urandom_range(0, 24) == 0)
						write_half_width(HW'($urandom_range(0, 15)));
					b.mean = pick_sample();
					send_beat(SW'(b.mean), (i == len - 1));
					predict_means(SW'(b.mean), (i == len - 1), 1'b1);
					sent++;
				end
			end
		end
		steady = 1'b0;

		sample_valid <= 1'b0;
		while (mean_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && mean_due_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
